/* design/header_footer_frame_parser_assert.svh */
// Assertion macros shared by the frame parser checkers.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef HEADER_FOOTER_FRAME_PARSER_ASSERT_SVH
`define HEADER_FOOTER_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HFP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, checked outside reset.
`define HFP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

/* design/hfp_pkg.sv */
// ----------------------------------------------------------------------------
// hfp_pkg
// Types, codes and constants shared by the header/footer frame parser.
// ----------------------------------------------------------------------------
package hfp_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int MLEN_W    = 4;
    localparam int PATTERN_W = 64;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_BUFFER_DEPTH   = 64;
    localparam int DEF_MAX_MARK_BYTES = 8;

    // Depth of the result queue in the back end.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING      = 3'd0,
        ST_COMPLETE     = 3'd1,
        ST_MISMATCH     = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_CLEARED      = 3'd4,
        ST_READ_OK      = 3'd5,
        ST_READ_RANGE   = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_LEN = 2'd0,
        CFG_HEADER_PAT = 2'd1,
        CFG_FOOTER_LEN = 2'd2,
        CFG_FOOTER_PAT = 2'd3
    } cfg_index_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [COUNT_W-1:0]   fill_count;
        logic [COUNT_W-1:0]   payload_length;
    } front_res_t;

    // One finished result as held in the queue.
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   fill_count;
        logic [COUNT_W-1:0]   payload_length;
        logic [BYTE_W-1:0]    read_byte;
    } result_t;

endpackage

/* design/hfp_ram.sv */
// ----------------------------------------------------------------------------
// hfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/hfp_front.sv */
// ----------------------------------------------------------------------------
// hfp_front
// Accepts items, holds the configuration and fill level, checks the header
// and footer marks, and drives the frame store ports.
// ----------------------------------------------------------------------------
module hfp_front import hfp_pkg::*; #(
    parameter int BUFFER_DEPTH   = DEF_BUFFER_DEPTH,
    parameter int MAX_MARK_BYTES = DEF_MAX_MARK_BYTES,
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1),
    localparam int ADDR_W = $clog2(BUFFER_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [KIND_W-1:0]    kind,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [INDEX_W-1:0]   read_index,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0] cfg_data,
    output front_res_t           front_res,
    output logic                 ram_we,
    output logic [ADDR_W-1:0]    ram_waddr,
    output logic [BYTE_W-1:0]    ram_wdata,
    output logic                 ram_re,
    output logic [ADDR_W-1:0]    ram_raddr
);

    localparam int CMP_W = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;

    logic [MLEN_W-1:0]    header_len_reg, header_len_next;
    logic [PATTERN_W-1:0] header_pat_reg, header_pat_next;
    logic [MLEN_W-1:0]    footer_len_reg, footer_len_next;
    logic [PATTERN_W-1:0] footer_pat_reg, footer_pat_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [BYTE_W-1:0]    head_reg [MAX_MARK_BYTES];
    logic [BYTE_W-1:0]    tail_reg [MAX_MARK_BYTES];
    logic [BYTE_W-1:0]    tail_next [MAX_MARK_BYTES];

    logic [MLEN_W-1:0]    hlen;
    logic [MLEN_W-1:0]    flen;
    logic [MLEN_W:0]      marks;
    logic [FILL_W-1:0]    fill_plus;
    logic                 store_full;
    logic                 header_bad;
    logic                 footer_good;
    logic [FILL_W-1:0]    plen_old;
    logic [FILL_W-1:0]    plen_after;
    logic                 index_in_range;
    logic                 do_append;
    status_t              status;
    logic [2:0]           fsel [MAX_MARK_BYTES];

    // Mark lengths above the supported maximum count as the maximum.
    assign hlen = (header_len_reg > MLEN_W'(MAX_MARK_BYTES)) ?
                  MLEN_W'(MAX_MARK_BYTES) : header_len_reg;
    assign flen = (footer_len_reg > MLEN_W'(MAX_MARK_BYTES)) ?
                  MLEN_W'(MAX_MARK_BYTES) : footer_len_reg;
    assign marks = {1'b0, hlen} + {1'b0, flen};

    assign store_full = (fill_reg == FILL_W'(BUFFER_DEPTH));
    assign fill_plus  = fill_reg + FILL_W'(1);

    // Payload length before and after the item.
    assign plen_old   = (fill_reg >= FILL_W'(marks)) ? fill_reg - FILL_W'(marks) : '0;
    assign plen_after = (fill_next >= FILL_W'(marks)) ? fill_next - FILL_W'(marks) : '0;

    // Newest bytes after a shift, newest in lane zero.
    always_comb
    begin
        tail_next[0] = data_byte;
        for (int k = 1; k < MAX_MARK_BYTES; k++)
        begin
            tail_next[k] = tail_reg[k-1];
        end
    end

    // Header prefix check over the bytes held after the append.
    always_comb
    begin
        logic [BYTE_W-1:0] cur;
        header_bad = 1'b0;
        for (int p = 0; p < MAX_MARK_BYTES; p++)
        begin
            cur = (int'(fill_reg) == p) ? data_byte : head_reg[p];
            if ((p < int'(hlen)) && (p <= int'(fill_reg)) &&
                (cur != header_pat_reg[8*p +: 8]))
            begin
                header_bad = 1'b1;
            end
        end
    end

    // Footer check: lane k holds footer byte flen-1-k.
    always_comb
    begin
        footer_good = (flen != '0) && (fill_plus >= FILL_W'(flen));
        for (int k = 0; k < MAX_MARK_BYTES; k++)
        begin
            fsel[k] = 3'(flen - MLEN_W'(1) - MLEN_W'(k));
            if ((k < int'(flen)) &&
                (tail_next[k] != footer_pat_reg[{fsel[k], 3'b000} +: 8]))
            begin
                footer_good = 1'b0;
            end
        end
    end

    assign index_in_range = (CMP_W'(read_index) < CMP_W'(plen_old));

    // Classification and next fill level.
    always_comb
    begin
        status    = ST_PENDING;
        fill_next = fill_reg;
        do_append = 1'b0;
        unique case (kind_t'(kind))
            KIND_APPEND:
            begin
                if (store_full)
                begin
                    status    = ST_OVERFLOW;
                    fill_next = '0;
                end
                else
                begin
                    do_append = 1'b1;
                    if (header_bad)
                    begin
                        status    = ST_MISMATCH;
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_plus;
                        status    = footer_good ? ST_COMPLETE : ST_PENDING;
                    end
                end
            end
            KIND_CLEAR:
            begin
                status    = ST_CLEARED;
                fill_next = '0;
            end
            KIND_READ:
            begin
                status = index_in_range ? ST_READ_OK : ST_READ_RANGE;
            end
            default:
            begin
                status = ST_PENDING;
            end
        endcase
    end

    // Result handed to the back end in the accept cycle.
    always_comb
    begin
        front_res.valid          = accept;
        front_res.status         = status;
        front_res.fill_count     = COUNT_W'(fill_next);
        front_res.payload_length = COUNT_W'(plen_after);
    end

    // Frame store ports.
    assign ram_we    = accept && do_append;
    assign ram_waddr = fill_reg[ADDR_W-1:0];
    assign ram_wdata = data_byte;
    assign ram_re    = accept && (kind_t'(kind) == KIND_READ);
    assign ram_raddr = ADDR_W'(COUNT_W'(hlen) + COUNT_W'(read_index));

    // Configuration register writes.
    always_comb
    begin
        header_len_next = header_len_reg;
        header_pat_next = header_pat_reg;
        footer_len_next = footer_len_reg;
        footer_pat_next = footer_pat_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEADER_LEN: header_len_next = cfg_data[MLEN_W-1:0];
                CFG_HEADER_PAT: header_pat_next = cfg_data;
                CFG_FOOTER_LEN: footer_len_next = cfg_data[MLEN_W-1:0];
                CFG_FOOTER_PAT: footer_pat_next = cfg_data;
                default:        header_len_next = header_len_reg;
            endcase
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_len_reg <= '0;
            header_pat_reg <= '0;
            footer_len_reg <= '0;
            footer_pat_reg <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            header_len_reg <= header_len_next;
            header_pat_reg <= header_pat_next;
            footer_len_reg <= footer_len_next;
            footer_pat_reg <= footer_pat_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Copies of the first and the newest bytes for the mark checks.
    always_ff @(posedge clk)
    begin
        if (accept && do_append)
        begin
            for (int p = 0; p < MAX_MARK_BYTES; p++)
            begin
                if (int'(fill_reg) == p)
                begin
                    head_reg[p] <= data_byte;
                end
            end
            for (int k = 0; k < MAX_MARK_BYTES; k++)
            begin
                tail_reg[k] <= tail_next[k];
            end
        end
    end

endmodule

/* design/hfp_back.sv */
// ----------------------------------------------------------------------------
// hfp_back
// Joins each classified item with its frame store read and queues the
// finished results for the output side.
// ----------------------------------------------------------------------------
module hfp_back import hfp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  front_res_t          front_res,
    input  logic [BYTE_W-1:0]   ram_rdata,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output result_t             head_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                stage_valid_reg;
    front_res_t          stage_reg;
    result_t             queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                q_push;
    logic                q_pop;
    result_t             joined;

    // An item in flight holds a queue slot, so the input stalls early enough.
    assign full  = (count_reg + CNT_W'(stage_valid_reg)) >= CNT_W'(QUEUE_DEPTH);
    assign empty = (count_reg == '0);

    // Join the staged item with the store data read in its accept cycle.
    always_comb
    begin
        joined.status         = stage_reg.status;
        joined.fill_count     = stage_reg.fill_count;
        joined.payload_length = stage_reg.payload_length;
        joined.read_byte      = (stage_reg.status == ST_READ_OK) ? ram_rdata : '0;
    end

    assign q_push   = stage_valid_reg;
    assign q_pop    = pop && !empty;
    assign head_res = queue_mem[rd_ptr_reg];

    // Queue pointers and occupancy.
    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(q_push) - CNT_W'(q_pop);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= front_res.valid;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (front_res.valid)
        begin
            stage_reg <= front_res;
        end
        if (q_push)
        begin
            queue_mem[wr_ptr_reg] <= joined;
        end
    end

endmodule

/* design/header_footer_frame_parser.sv */
// A result reaches the output ports through the stage register and then the result queue.
// Throughput: one item per cycle while full is low; the frame store has a registered
// read port, read in the accept cycle and joined with the classified item in the next cycle.
// full rises when the four-entry result queue plus the item in flight fill it up.
// Reset (rst_n low, asynchronous) empties the buffer and queue and clears all
// configuration registers to zero; the frame store itself is not cleared.
// ----------------------------------------------------------------------------
// header_footer_frame_parser
// Collects serial bytes into a frame, checks header and footer marks and
// serves payload byte reads, with a queue between classification and output.
// ----------------------------------------------------------------------------
module header_footer_frame_parser import hfp_pkg::*; #(
    parameter int BUFFER_DEPTH   = DEF_BUFFER_DEPTH,
    parameter int MAX_MARK_BYTES = DEF_MAX_MARK_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_W-1:0]    kind,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [INDEX_W-1:0]   read_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [STATUS_W-1:0]  status,
    output logic [COUNT_W-1:0]   fill_count,
    output logic [COUNT_W-1:0]   payload_length,
    output logic [BYTE_W-1:0]    read_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic              accept;
    front_res_t        front_res;
    result_t           head_res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    // Front end: classification, marks and fill level.
    hfp_front #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .MAX_MARK_BYTES (MAX_MARK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind),
        .data_byte  (data_byte),
        .read_index (read_index),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .front_res  (front_res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    // Frame store.
    hfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back end: read join and result queue.
    hfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .front_res (front_res),
        .ram_rdata (ram_rdata),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head_res  (head_res)
    );

    assign status         = head_res.status;
    assign fill_count     = head_res.fill_count;
    assign payload_length = head_res.payload_length;
    assign read_byte      = head_res.read_byte;

endmodule

/* design/hfp_checker.sv */
// ----------------------------------------------------------------------------
// hfp_checker
// Port-level checks on the results of the frame parser, bound to the top.
// ----------------------------------------------------------------------------
`include "header_footer_frame_parser_assert.svh"

module hfp_checker import hfp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  logic                pop,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  fill_count,
    input  logic [COUNT_W-1:0]  payload_length,
    input  logic [BYTE_W-1:0]   read_byte
);

    logic shown;
    logic dropped;

    // A result is on the ports, and it reports that the buffer was emptied.
    assign shown   = !empty;
    assign dropped = (status == ST_MISMATCH) || (status == ST_OVERFLOW) ||
                     (status == ST_CLEARED);

    // Only a successful read carries a data byte.
    `HFP_ASSERT_NOW(a_byte_only_on_read, shown && (status != ST_READ_OK), read_byte == '0)

    // A mismatch, overflow or clear always leaves the buffer empty.
    `HFP_ASSERT_NOW(a_drop_empties, shown && dropped, fill_count == '0)

    // A successful read needs a payload of at least one byte.
    `HFP_ASSERT_NOW(a_read_has_payload, shown && (status == ST_READ_OK), payload_length != '0)

    // A waiting result stays put until it is taken.
    `HFP_ASSERT_NEXT(a_result_holds, shown && !pop, !empty && $stable(status) && $stable(fill_count))

endmodule

bind header_footer_frame_parser hfp_checker u_hfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .fill_count     (fill_count),
    .payload_length (payload_length),
    .read_byte      (read_byte)
);
